>>> rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types, codes and the microcode ROM of the MessagePack value encoder.
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int FUNC_W  = 4;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int CAP_W   = 32;

    // Request function codes
    localparam logic [FUNC_W-1:0] FN_NIL     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_BOOL    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_UINT    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_INT     = 4'd3;
    localparam logic [FUNC_W-1:0] FN_F32     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_F64     = 4'd5;
    localparam logic [FUNC_W-1:0] FN_STR     = 4'd6;
    localparam logic [FUNC_W-1:0] FN_BIN     = 4'd7;
    localparam logic [FUNC_W-1:0] FN_MAP     = 4'd8;
    localparam logic [FUNC_W-1:0] FN_ARRAY   = 4'd9;
    localparam logic [FUNC_W-1:0] FN_PAYLOAD = 4'd10;
    localparam logic [FUNC_W-1:0] FN_RESTART = 4'd11;

    // MessagePack tags
    localparam logic [7:0] TAG_NIL     = 8'hc0;
    localparam logic [7:0] TAG_FALSE   = 8'hc2;
    localparam logic [7:0] TAG_TRUE    = 8'hc3;
    localparam logic [7:0] TAG_BIN8    = 8'hc4;
    localparam logic [7:0] TAG_BIN16   = 8'hc5;
    localparam logic [7:0] TAG_BIN32   = 8'hc6;
    localparam logic [7:0] TAG_F32     = 8'hca;
    localparam logic [7:0] TAG_F64     = 8'hcb;
    localparam logic [7:0] TAG_U8      = 8'hcc;
    localparam logic [7:0] TAG_U16     = 8'hcd;
    localparam logic [7:0] TAG_U32     = 8'hce;
    localparam logic [7:0] TAG_U64     = 8'hcf;
    localparam logic [7:0] TAG_I8      = 8'hd0;
    localparam logic [7:0] TAG_I16     = 8'hd1;
    localparam logic [7:0] TAG_I32     = 8'hd2;
    localparam logic [7:0] TAG_I64     = 8'hd3;
    localparam logic [7:0] TAG_STR8    = 8'hd9;
    localparam logic [7:0] TAG_STR16   = 8'hda;
    localparam logic [7:0] TAG_STR32   = 8'hdb;
    localparam logic [7:0] TAG_ARR16   = 8'hdc;
    localparam logic [7:0] TAG_ARR32   = 8'hdd;
    localparam logic [7:0] TAG_MAP16   = 8'hde;
    localparam logic [7:0] TAG_MAP32   = 8'hdf;
    localparam logic [7:0] TAG_FIXMAP  = 8'h80;
    localparam logic [7:0] TAG_FIXARR  = 8'h90;
    localparam logic [7:0] TAG_FIXSTR  = 8'ha0;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DECODE,
        OP_CHECK,
        OP_BINCHK,
        OP_EMIT_TAG,
        OP_EMIT_DATA,
        OP_EMPTY
    } t_op;

    typedef enum logic [1:0] {
        CND_NEVER,
        CND_NONE,
        CND_NB_ZERO,
        CND_LAST
    } t_cond;

    typedef logic [2:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uword;

    typedef struct packed {
        logic none;
        logic nb_zero;
        logic last;
    } t_flags;

    localparam t_step ST_IDLE  = 3'd0;
    localparam t_step ST_DEC   = 3'd1;
    localparam t_step ST_CHK   = 3'd2;
    localparam t_step ST_BCHK  = 3'd3;
    localparam t_step ST_TAG   = 3'd4;
    localparam t_step ST_DATA  = 3'd5;
    localparam t_step ST_EMPTY = 3'd6;

    function automatic t_uword ucode_rom(input t_step addr);
        t_uword w;
        case (addr)
            ST_IDLE:  w = '{OP_IDLE,      CND_NEVER,   ST_IDLE,  ST_DEC};
            ST_DEC:   w = '{OP_DECODE,    CND_NEVER,   ST_IDLE,  ST_CHK};
            ST_CHK:   w = '{OP_CHECK,     CND_NEVER,   ST_IDLE,  ST_BCHK};
            ST_BCHK:  w = '{OP_BINCHK,    CND_NONE,    ST_EMPTY, ST_TAG};
            ST_TAG:   w = '{OP_EMIT_TAG,  CND_NB_ZERO, ST_IDLE,  ST_DATA};
            ST_DATA:  w = '{OP_EMIT_DATA, CND_LAST,    ST_IDLE,  ST_DATA};
            ST_EMPTY: w = '{OP_EMPTY,     CND_NEVER,   ST_IDLE,  ST_IDLE};
            default:  w = '{OP_IDLE,      CND_NEVER,   ST_IDLE,  ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/mpe_in_if.sv
// ----------------------------------------------------------------------------
// mpe_in_if
// Request channel: one value to encode per accepted request.
// ----------------------------------------------------------------------------
interface mpe_in_if;
    logic                          valid;
    logic                          ready;
    logic [mpe_pkg::FUNC_W-1:0]    func;
    logic [mpe_pkg::VALUE_W-1:0]   value;
    logic [mpe_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, func, value, data_byte, input ready);
    modport sink   (input valid, func, value, data_byte, output ready);
endinterface

>>> rtl/mpe_out_if.sv
// ----------------------------------------------------------------------------
// mpe_out_if
// Result channel: one encoded byte with status and last marker.
// ----------------------------------------------------------------------------
interface mpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [mpe_pkg::BYTE_W-1:0]  out_byte;
    logic                        byte_valid;
    logic                        status;
    logic                        last;

    modport source (output valid, out_byte, byte_valid, status, last, input ready);
    modport sink   (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

>>> rtl/mpe_cfg_if.sv
// ----------------------------------------------------------------------------
// mpe_cfg_if
// Configuration write channel for the buffer capacity register.
// ----------------------------------------------------------------------------
interface mpe_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mpe_pkg::CAP_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/mpe_seq.sv
// ----------------------------------------------------------------------------
// mpe_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module mpe_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_op_done,
    input  mpe_pkg::t_flags i_flags,
    output mpe_pkg::t_op    o_op
);

    mpe_pkg::t_step  r_step;
    mpe_pkg::t_step  n_step;
    mpe_pkg::t_uword w;
    logic            take;

    always_comb begin
        w = mpe_pkg::ucode_rom(r_step);
        unique case (w.cond)
            mpe_pkg::CND_NEVER:   take = 1'b0;
            mpe_pkg::CND_NONE:    take = i_flags.none;
            mpe_pkg::CND_NB_ZERO: take = i_flags.nb_zero;
            mpe_pkg::CND_LAST:    take = i_flags.last;
            default:              take = 1'b0;
        endcase
        // hold the step until its operation completes
        n_step = r_step;
        if (i_op_done) begin
            n_step = take ? w.jmp : w.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mpe_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op = w.op;

endmodule

>>> rtl/msgpack_value_encoder.sv
// ----------------------------------------------------------------------------
// msgpack_value_encoder
// Encodes one value per request as big-endian MessagePack bytes under a
// byte budget reloaded from the capacity register.
// ----------------------------------------------------------------------------
// Sequence: accept in idle, then decode, check and bin check, then one result
//   per cycle while the output is taken.
// Results: n per request, n = 1..9, set by the microcode program, which emits one
//   byte per step; the next request is accepted only once it is back in idle.
// Reset: synchronous active low; budget and capacity clear to zero,
//   sequencer returns to idle, output holds no result.
// ----------------------------------------------------------------------------
module msgpack_value_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpe_in_if.sink       i_in,
    mpe_cfg_if.sink      i_cfg,
    mpe_out_if.source    o_out
);

    // Sequencer control
    mpe_pkg::t_op    op;
    mpe_pkg::t_flags flags;
    logic            op_done;
    logic            out_free;
    logic            in_acc;

    // Latched request
    logic [mpe_pkg::FUNC_W-1:0]  r_func;
    logic [mpe_pkg::VALUE_W-1:0] r_value;
    logic [mpe_pkg::BYTE_W-1:0]  r_data;

    // Decoded header: tag byte plus r_nb value bytes
    logic [7:0] r_tag;
    logic [3:0] r_nb;
    logic       r_none;
    logic       r_stat;
    logic       r_str;
    logic       r_bin;

    // Budget and capacity
    logic [mpe_pkg::CAP_W-1:0] r_budget;
    logic [mpe_pkg::CAP_W-1:0] r_cap;

    // Output register
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_bvalid;
    logic       r_o_stat;
    logic       r_o_last;

    // Decode results
    logic [7:0] d_tag;
    logic [3:0] d_nb;
    logic       d_none;
    logic       d_stat;
    logic       d_str;
    logic       d_bin;

    logic       hi_zero;
    logic       le_7f;
    logic       le_ff;
    logic       le_ffff;
    logic       le_1f;
    logic       le_0f;

    // Fit check
    logic [3:0]              hlen;
    logic [mpe_pkg::CAP_W:0] need;
    logic                    fits;
    logic [2:0]              byte_sel;
    logic [7:0]              data_out;

    mpe_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_done (op_done),
        .i_flags   (flags),
        .o_op      (op)
    );

    assign i_in.ready  = (op == mpe_pkg::OP_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid & i_in.ready;
    assign out_free    = !r_o_valid || o_out.ready;

    assign flags.none    = r_none;
    assign flags.nb_zero = (r_nb == 4'd0);
    assign flags.last    = (r_nb == 4'd1);

    // Idle waits for a request, emit steps wait for a free output slot
    always_comb begin
        unique case (op)
            mpe_pkg::OP_IDLE:      op_done = in_acc;
            mpe_pkg::OP_EMIT_TAG,
            mpe_pkg::OP_EMIT_DATA,
            mpe_pkg::OP_EMPTY:     op_done = out_free;
            default:               op_done = 1'b1;
        endcase
    end

    // Range tests on the latched value
    assign hi_zero = (r_value[63:32] == 32'd0);
    assign le_0f   = hi_zero && (r_value[31:4] == 28'd0);
    assign le_1f   = hi_zero && (r_value[31:5] == 27'd0);
    assign le_7f   = hi_zero && (r_value[31:7] == 25'd0);
    assign le_ff   = hi_zero && (r_value[31:8] == 24'd0);
    assign le_ffff = hi_zero && (r_value[31:16] == 16'd0);

    // Pick the smallest form; single-byte forms carry everything in the tag
    always_comb begin
        d_tag  = 8'd0;
        d_nb   = 4'd0;
        d_none = 1'b0;
        d_stat = 1'b0;
        d_str  = 1'b0;
        d_bin  = 1'b0;
        case (r_func)
            mpe_pkg::FN_NIL:  d_tag = mpe_pkg::TAG_NIL;
            mpe_pkg::FN_BOOL: d_tag = (r_value != '0) ? mpe_pkg::TAG_TRUE : mpe_pkg::TAG_FALSE;
            mpe_pkg::FN_UINT, mpe_pkg::FN_INT: begin
                if (!r_value[63] || r_func == mpe_pkg::FN_UINT) begin
                    priority if (le_7f) begin
                        d_tag = r_value[7:0];
                    end else if (le_ff) begin
                        d_tag = mpe_pkg::TAG_U8;  d_nb = 4'd1;
                    end else if (le_ffff) begin
                        d_tag = mpe_pkg::TAG_U16; d_nb = 4'd2;
                    end else if (hi_zero) begin
                        d_tag = mpe_pkg::TAG_U32; d_nb = 4'd4;
                    end else begin
                        d_tag = mpe_pkg::TAG_U64; d_nb = 4'd8;
                    end
                end else begin
                    // negative: count sign-extension ones
                    priority if (&r_value[63:5]) begin
                        d_tag = r_value[7:0];
                    end else if (&r_value[63:7]) begin
                        d_tag = mpe_pkg::TAG_I8;  d_nb = 4'd1;
                    end else if (&r_value[63:15]) begin
                        d_tag = mpe_pkg::TAG_I16; d_nb = 4'd2;
                    end else if (&r_value[63:31]) begin
                        d_tag = mpe_pkg::TAG_I32; d_nb = 4'd4;
                    end else begin
                        d_tag = mpe_pkg::TAG_I64; d_nb = 4'd8;
                    end
                end
            end
            mpe_pkg::FN_F32: begin
                d_tag = mpe_pkg::TAG_F32; d_nb = 4'd4;
            end
            mpe_pkg::FN_F64: begin
                d_tag = mpe_pkg::TAG_F64; d_nb = 4'd8;
            end
            mpe_pkg::FN_STR: begin
                d_str = 1'b1;
                priority if (!hi_zero) begin
                    d_none = 1'b1; d_stat = 1'b1; d_str = 1'b0;
                end else if (le_1f) begin
                    d_tag = mpe_pkg::TAG_FIXSTR | r_value[7:0];
                end else if (le_ff) begin
                    d_tag = mpe_pkg::TAG_STR8;  d_nb = 4'd1;
                end else if (le_ffff) begin
                    d_tag = mpe_pkg::TAG_STR16; d_nb = 4'd2;
                end else begin
                    d_tag = mpe_pkg::TAG_STR32; d_nb = 4'd4;
                end
            end
            mpe_pkg::FN_BIN: begin
                d_bin = 1'b1;
                priority if (!hi_zero) begin
                    d_none = 1'b1; d_stat = 1'b1; d_bin = 1'b0;
                end else if (le_ff) begin
                    d_tag = mpe_pkg::TAG_BIN8;  d_nb = 4'd1;
                end else if (le_ffff) begin
                    d_tag = mpe_pkg::TAG_BIN16; d_nb = 4'd2;
                end else begin
                    d_tag = mpe_pkg::TAG_BIN32; d_nb = 4'd4;
                end
            end
            mpe_pkg::FN_MAP, mpe_pkg::FN_ARRAY: begin
                priority if (!hi_zero) begin
                    d_none = 1'b1; d_stat = 1'b1;
                end else if (le_0f) begin
                    d_tag = ((r_func == mpe_pkg::FN_MAP) ? mpe_pkg::TAG_FIXMAP
                                                         : mpe_pkg::TAG_FIXARR)
                            | r_value[7:0];
                end else if (le_ffff) begin
                    d_tag = (r_func == mpe_pkg::FN_MAP) ? mpe_pkg::TAG_MAP16
                                                        : mpe_pkg::TAG_ARR16;
                    d_nb  = 4'd2;
                end else begin
                    d_tag = (r_func == mpe_pkg::FN_MAP) ? mpe_pkg::TAG_MAP32
                                                        : mpe_pkg::TAG_ARR32;
                    d_nb  = 4'd4;
                end
            end
            mpe_pkg::FN_PAYLOAD: d_tag = r_data;
            default:             d_none = 1'b1;   // restart and unused codes
        endcase
    end

    // Header plus declared str payload must fit the budget
    assign hlen = r_nb + 4'd1;
    assign need = {{(mpe_pkg::CAP_W - 3){1'b0}}, hlen}
                + {1'b0, (r_str ? r_value[31:0] : 32'd0)};
    assign fits = ({1'b0, r_budget} >= need);

    // Value bytes leave most significant first
    assign byte_sel = 3'(r_nb - 4'd1);
    assign data_out = r_value[{byte_sel, 3'b000} +: 8];

    // Control registers: budget, capacity, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget  <= '0;
            r_cap     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
            if (op == mpe_pkg::OP_DECODE && r_func == mpe_pkg::FN_RESTART) begin
                r_budget <= r_cap;
            end
            if (op == mpe_pkg::OP_CHECK && !r_none && fits) begin
                r_budget <= r_budget - {{(mpe_pkg::CAP_W - 4){1'b0}}, hlen};
            end
            if ((op == mpe_pkg::OP_EMIT_TAG || op == mpe_pkg::OP_EMIT_DATA
                 || op == mpe_pkg::OP_EMPTY) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func  <= i_in.func;
            r_value <= i_in.value;
            r_data  <= i_in.data_byte;
        end
        unique case (op)
            mpe_pkg::OP_DECODE: begin
                r_tag  <= d_tag;
                r_nb   <= d_nb;
                r_none <= d_none;
                r_stat <= d_stat;
                r_str  <= d_str;
                r_bin  <= d_bin;
            end
            mpe_pkg::OP_CHECK: begin
                // drop the whole header on overflow
                if (!r_none && !fits) begin
                    r_none <= 1'b1;
                    r_stat <= 1'b1;
                end
            end
            mpe_pkg::OP_BINCHK: begin
                if (r_bin && !r_none && (r_budget < r_value[31:0])) begin
                    r_stat <= 1'b1;
                end
            end
            mpe_pkg::OP_EMIT_TAG: begin
                if (out_free) begin
                    r_o_byte   <= r_tag;
                    r_o_bvalid <= 1'b1;
                    r_o_stat   <= r_stat;
                    r_o_last   <= (r_nb == 4'd0);
                end
            end
            mpe_pkg::OP_EMIT_DATA: begin
                if (out_free) begin
                    r_o_byte   <= data_out;
                    r_o_bvalid <= 1'b1;
                    r_o_stat   <= r_stat;
                    r_o_last   <= (r_nb == 4'd1);
                    r_nb       <= r_nb - 4'd1;
                end
            end
            mpe_pkg::OP_EMPTY: begin
                if (out_free) begin
                    r_o_byte   <= 8'd0;
                    r_o_bvalid <= 1'b0;
                    r_o_stat   <= r_stat;
                    r_o_last   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.byte_valid = r_o_bvalid;
    assign o_out.status     = r_o_stat;
    assign o_out.last       = r_o_last;

endmodule

>>> tb/sv/msgpack_value_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgpack_value_encoder_test
// Self-checking regression for the MessagePack value encoder. Requests are
// fed from a queue through a randomly throttled driver, every accepted request
// is encoded by a local byte-level predictor under the same byte budget, and
// each result taken from the output channel is checked field by field against
// the oldest predicted byte. Several capacity settings are exercised, 0 and
// all-ones among them, each followed by a restart and a burst of requests.
// ----------------------------------------------------------------------------
module msgpack_value_encoder_test;

    // Stretch of cycles without any handshake that counts as a hang
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let pass once the last expected byte has come
    localparam int DRAIN_CYCLES   = 8;
    // Most mismatch lines to print; all mismatches are still counted
    localparam int PRINT_LIMIT    = 100;

    typedef struct {
        logic [mpe_pkg::FUNC_W-1:0]  fn;
        logic [mpe_pkg::VALUE_W-1:0] val;
        logic [mpe_pkg::BYTE_W-1:0]  db;
    } t_request;

    typedef struct packed {
        logic [mpe_pkg::BYTE_W-1:0] out_byte;
        logic                       byte_valid;
        logic                       status;
        logic                       last;
    } t_enc_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpe_in_if  req_if ();
    mpe_out_if res_if ();
    mpe_cfg_if cap_if ();

    msgpack_value_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .i_cfg   (cap_if),
        .o_out   (res_if)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the capacity register and the budget
    // ------------------------------------------------------------------------
    logic [mpe_pkg::CAP_W-1:0]  capacity_copy;
    logic [mpe_pkg::CAP_W-1:0]  budget_left;
    logic [7:0]                 hdr_buf [9];
    int                         hdr_len;

    t_request          req_pending [$];
    t_enc_byte         enc_expected [$];

    int                mismatches;
    int                quiet_cycles;

    // Driver / receiver throttling, in percent per accepted request / per cycle
    int                send_pct;
    int                recv_pct;
    int                send_gap;
    int                recv_stall;
    bit                holding;
    bit                req_taken;
    t_request          req_cur;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Append one byte to the header under construction
    function automatic void hdr_put(input logic [7:0] b);
        hdr_buf[hdr_len] = b;
        hdr_len++;
    endfunction

    // Append a tag followed by the low nbytes of v, most significant first
    function automatic void hdr_tag(input logic [7:0] tag, input logic [63:0] v,
                                    input int nbytes);
        hdr_put(tag);
        for (int i = nbytes - 1; i >= 0; i--)
            hdr_put(v[8*i +: 8]);
    endfunction

    // Smallest unsigned form: positive fixint, then u8/u16/u32/u64
    function automatic void hdr_uint(input logic [63:0] v);
        if (v <= 64'd127)                 hdr_put(v[7:0]);
        else if (v <= 64'hff)             hdr_tag(mpe_pkg::TAG_U8, v, 1);
        else if (v <= 64'hffff)           hdr_tag(mpe_pkg::TAG_U16, v, 2);
        else if (v <= 64'hffff_ffff)      hdr_tag(mpe_pkg::TAG_U32, v, 4);
        else                              hdr_tag(mpe_pkg::TAG_U64, v, 8);
    endfunction

    // Map and array headers share one sizing rule
    function automatic void hdr_count(input logic [63:0] v, input logic [7:0] fix,
                                      input logic [7:0] t16, input logic [7:0] t32);
        if (v <= 64'd15)                  hdr_put(fix | v[7:0]);
        else if (v <= 64'hffff)           hdr_tag(t16, v, 2);
        else                              hdr_tag(t32, v, 4);
    endfunction

    // ------------------------------------------------------------------------
    // Encode one accepted request: update the budget and queue its bytes
    // ------------------------------------------------------------------------
    function automatic void encode_request(input t_request rq);
        logic [63:0] v;
        logic [63:0] extra;
        logic        bin_chk;
        logic        st;
        logic        too_long;
        v        = rq.val;
        extra    = 64'd0;
        bin_chk  = 1'b0;
        st       = 1'b0;
        too_long = (v[63:32] != 32'd0);
        hdr_len  = 0;
        case (rq.fn)
            mpe_pkg::FN_NIL:   hdr_put(mpe_pkg::TAG_NIL);
            mpe_pkg::FN_BOOL:  hdr_put((v != 64'd0) ? mpe_pkg::TAG_TRUE : mpe_pkg::TAG_FALSE);
            mpe_pkg::FN_UINT:  hdr_uint(v);
            mpe_pkg::FN_INT: begin
                if (!v[63])                              hdr_uint(v);
                else if (v >= 64'hffff_ffff_ffff_ffe0)   hdr_put(v[7:0]);
                else if (v >= 64'hffff_ffff_ffff_ff80)   hdr_tag(mpe_pkg::TAG_I8, v, 1);
                else if (v >= 64'hffff_ffff_ffff_8000)   hdr_tag(mpe_pkg::TAG_I16, v, 2);
                else if (v >= 64'hffff_ffff_8000_0000)   hdr_tag(mpe_pkg::TAG_I32, v, 4);
                else                                     hdr_tag(mpe_pkg::TAG_I64, v, 8);
            end
            mpe_pkg::FN_F32:   hdr_tag(mpe_pkg::TAG_F32, {32'd0, v[31:0]}, 4);
            mpe_pkg::FN_F64:   hdr_tag(mpe_pkg::TAG_F64, v, 8);
            mpe_pkg::FN_STR: begin
                if (too_long) begin
                    st = 1'b1;
                end else begin
                    if (v <= 64'd31)            hdr_put(mpe_pkg::TAG_FIXSTR | v[7:0]);
                    else if (v <= 64'hff)       hdr_tag(mpe_pkg::TAG_STR8, v, 1);
                    else if (v <= 64'hffff)     hdr_tag(mpe_pkg::TAG_STR16, v, 2);
                    else                        hdr_tag(mpe_pkg::TAG_STR32, v, 4);
                    // the declared payload has to fit as well
                    extra = v;
                end
            end
            mpe_pkg::FN_BIN: begin
                if (too_long) begin
                    st = 1'b1;
                end else begin
                    if (v <= 64'hff)            hdr_tag(mpe_pkg::TAG_BIN8, v, 1);
                    else if (v <= 64'hffff)     hdr_tag(mpe_pkg::TAG_BIN16, v, 2);
                    else                        hdr_tag(mpe_pkg::TAG_BIN32, v, 4);
                    bin_chk = 1'b1;
                end
            end
            mpe_pkg::FN_MAP: begin
                if (too_long) st = 1'b1;
                else          hdr_count(v, mpe_pkg::TAG_FIXMAP, mpe_pkg::TAG_MAP16,
                                        mpe_pkg::TAG_MAP32);
            end
            mpe_pkg::FN_ARRAY: begin
                if (too_long) st = 1'b1;
                else          hdr_count(v, mpe_pkg::TAG_FIXARR, mpe_pkg::TAG_ARR16,
                                        mpe_pkg::TAG_ARR32);
            end
            mpe_pkg::FN_PAYLOAD: hdr_put(rq.db);
            mpe_pkg::FN_RESTART: budget_left = capacity_copy;
            default: ;
        endcase

        if (hdr_len > 0) begin
            if ({32'd0, budget_left} < 64'(hdr_len) + extra) begin
                // header does not fit: drop it, report overflow
                st      = 1'b1;
                hdr_len = 0;
            end else begin
                budget_left = budget_left - 32'(hdr_len);
                // bin payload is checked against what is left after the header
                if (bin_chk && ({32'd0, budget_left} < v)) st = 1'b1;
            end
        end

        if (hdr_len == 0) begin
            enc_expected.push_back('{out_byte: 8'h00, byte_valid: 1'b0, status: st,
                                     last: 1'b1});
        end else begin
            for (int k = 0; k < hdr_len; k++)
                enc_expected.push_back('{out_byte: hdr_buf[k], byte_valid: 1'b1, status: st,
                                         last: (k == hdr_len - 1)});
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample all handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_enc_byte want;
        bit        any_fire;
        req_taken <= req_if.valid && req_if.ready;
        if (i_rst_n) begin
            any_fire = 1'b0;
            if (cap_if.valid && cap_if.ready) begin
                capacity_copy = cap_if.data;
                any_fire      = 1'b1;
            end
            if (req_if.valid && req_if.ready) begin
                encode_request('{fn: req_if.func, val: req_if.value, db: req_if.data_byte});
                any_fire = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                any_fire = 1'b1;
                if (enc_expected.size() == 0) begin
                    report_mismatch("result with nothing pending, out_byte",
                                    64'(res_if.out_byte), 64'd0);
                end else begin
                    want = enc_expected.pop_front();
                    if (res_if.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(res_if.out_byte), 64'(want.out_byte));
                    if (res_if.byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", 64'(res_if.byte_valid),
                                        64'(want.byte_valid));
                    if (res_if.status !== want.status)
                        report_mismatch("status", 64'(res_if.status), 64'(want.status));
                    if (res_if.last !== want.last)
                        report_mismatch("last", 64'(res_if.last), 64'(want.last));
                end
            end
            if (any_fire) quiet_cycles = 0;
            else          quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: present queued requests at the falling edge, with gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (req_taken) begin
            holding = 1'b0;
            // insert an idle burst after some requests
            if (send_pct != 0 && $urandom_range(0, 99) < send_pct)
                send_gap = $urandom_range(1, 13);
        end
        if (!holding) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (req_pending.size() > 0) begin
                req_cur = req_pending.pop_front();
                holding = 1'b1;
            end
        end
        req_if.valid     <= holding;
        req_if.func      <= req_cur.fn;
        req_if.value     <= req_cur.val;
        req_if.data_byte <= req_cur.db;
    end

    // Result receiver: hold ready low for random bursts
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            recv_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (recv_pct != 0 && $urandom_range(0, 99) < recv_pct)
                recv_stall = $urandom_range(1, 13);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_req(input logic [mpe_pkg::FUNC_W-1:0] fn,
                                     input logic [63:0] v, input logic [7:0] db);
        req_pending.push_back('{fn: fn, val: v, db: db});
    endfunction

    // Values biased toward the encoding boundaries, with full-width noise
    function automatic logic [63:0] rand_value();
        logic [63:0] bounds [20] = '{
            64'd0, 64'd15, 64'd16, 64'd31, 64'd32, 64'd127, 64'd128, 64'hff, 64'h100,
            64'hffff, 64'h1_0000, 64'hffff_ffff, 64'h1_0000_0000,
            64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
            64'hffff_ffff_ffff_ffe0, 64'hffff_ffff_ffff_ff80,
            64'hffff_ffff_ffff_8000, 64'hffff_ffff_8000_0000, 64'hffff_ffff_ffff_ffff};
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 40));
            1:       return bounds[$urandom_range(0, 19)] + 64'($urandom_range(0, 2)) - 64'd1;
            2:       return {$urandom, $urandom};
            default: return 64'($urandom) >> $urandom_range(0, 31);
        endcase
    endfunction

    // Mostly well-formed str/bin sequences, mixed with scalars and noise
    task automatic add_random_requests(input int n);
        int          added;
        int          pick;
        int          cut;
        logic [63:0] len;
        logic [3:0]  fn;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                fn  = $urandom_range(0, 1) ? mpe_pkg::FN_STR : mpe_pkg::FN_BIN;
                len = ($urandom_range(0, 4) != 0) ? 64'($urandom_range(0, 6)) : rand_value();
                push_req(fn, len, 8'($urandom));
                added++;
                if (len <= 64'd6) begin
                    // now and then cut the payload short
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(len)) : 0;
                    for (int k = 0; k < int'(len) - cut; k++) begin
                        push_req(mpe_pkg::FN_PAYLOAD, rand_value(), 8'($urandom));
                        added++;
                    end
                end
            end else if (pick < 30) begin
                push_req(mpe_pkg::FN_RESTART, rand_value(), 8'($urandom));
                added++;
            end else if (pick < 38) begin
                push_req($urandom_range(0, 1) ? mpe_pkg::FN_MAP : mpe_pkg::FN_ARRAY,
                         rand_value(), 8'($urandom));
                added++;
            end else if (pick < 42) begin
                // unused codes give an empty result and do not count
                push_req(mpe_pkg::FN_RESTART + 4'($urandom_range(1, 4)), rand_value(),
                         8'($urandom));
            end else if (pick < 50) begin
                push_req(mpe_pkg::FN_PAYLOAD, rand_value(), 8'($urandom));
                added++;
            end else begin
                push_req(4'($urandom_range(mpe_pkg::FN_NIL, mpe_pkg::FN_F64)), rand_value(),
                         8'($urandom));
                added++;
            end
        end
    endtask

    // Wait until no request is queued or in flight and every byte has come
    task automatic settle();
        do begin
            @(negedge i_clk);
            #1;
        end while (req_pending.size() != 0 || holding || enc_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [mpe_pkg::CAP_W-1:0] cap);
        @(negedge i_clk);
        cap_if.valid <= 1'b1;
        cap_if.data  <= cap;
        @(posedge i_clk);
        while (!cap_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cap_if.valid <= 1'b0;
    endtask

    // One setting: block is idle, load the capacity, restart, then traffic
    task automatic run_phase(input logic [mpe_pkg::CAP_W-1:0] cap, input int n,
                             input int s_pct, input int r_pct);
        settle();
        write_capacity(cap);
        #1;
        send_pct = s_pct;
        recv_pct = r_pct;
        push_req(mpe_pkg::FN_RESTART, 64'd0, 8'($urandom));
        add_random_requests(n);
    endtask

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("msgpack_value_encoder regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // drive every input to a known value from time zero
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.func      = mpe_pkg::FN_NIL;
        req_if.value     = 64'd0;
        req_if.data_byte = 8'd0;
        res_if.ready     = 1'b0;
        cap_if.valid     = 1'b0;
        cap_if.data      = '0;
        req_cur          = '{fn: mpe_pkg::FN_NIL, val: 64'd0, db: 8'd0};
        capacity_copy    = '0;
        budget_left      = '0;
        mismatches       = 0;
        quiet_cycles     = 0;
        send_pct         = 20;
        recv_pct         = 20;
        send_gap         = 0;
        recv_stall       = 0;
        holding          = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: widest budget, every function and its extremes
        write_capacity(32'hffff_ffff);
        #1;
        push_req(mpe_pkg::FN_RESTART, 64'd0,                  8'h00);
        push_req(mpe_pkg::FN_NIL,     64'hffff_ffff_ffff_ffff, 8'hff);
        push_req(mpe_pkg::FN_BOOL,    64'd0,                  8'h00);
        // only the top bit set still means true
        push_req(mpe_pkg::FN_BOOL,    64'h8000_0000_0000_0000, 8'h00);
        push_req(mpe_pkg::FN_UINT,    64'hffff_ffff_ffff_ffff, 8'h00);
        push_req(mpe_pkg::FN_UINT,    64'd0,                  8'h00);
        push_req(mpe_pkg::FN_INT,     64'h8000_0000_0000_0000, 8'h00);
        push_req(mpe_pkg::FN_INT,     64'hffff_ffff_ffff_ffff, 8'h00);
        // upper half of the value is dropped for float32
        push_req(mpe_pkg::FN_F32,     64'hffff_ffff_ffff_ffff, 8'h00);
        push_req(mpe_pkg::FN_F64,     64'hffff_ffff_ffff_ffff, 8'h00);
        push_req(mpe_pkg::FN_STR,     64'd31,                 8'h00);
        push_req(mpe_pkg::FN_STR,     64'd32,                 8'h00);
        push_req(mpe_pkg::FN_STR,     64'h1_0000_0000,        8'h00);
        push_req(mpe_pkg::FN_BIN,     64'd0,                  8'h00);
        // bin header fits, payload does not
        push_req(mpe_pkg::FN_BIN,     64'hffff_ffff,          8'h00);
        push_req(mpe_pkg::FN_MAP,     64'd15,                 8'h00);
        push_req(mpe_pkg::FN_MAP,     64'h1_0000_0000,        8'h00);
        push_req(mpe_pkg::FN_ARRAY,   64'd16,                 8'h00);
        push_req(mpe_pkg::FN_ARRAY,   64'hffff_ffff,          8'h00);
        push_req(mpe_pkg::FN_PAYLOAD, 64'd0,                  8'hff);
        push_req(mpe_pkg::FN_PAYLOAD, 64'hffff_ffff_ffff_ffff, 8'h00);
        push_req(mpe_pkg::FN_RESTART + 4'd1, 64'd0,           8'h00);
        push_req(4'hf,                64'hffff_ffff_ffff_ffff, 8'hff);

        // directed: empty buffer, everything after the restart overflows
        settle();
        write_capacity(32'd0);
        #1;
        push_req(mpe_pkg::FN_RESTART, 64'd0,                  8'h00);
        push_req(mpe_pkg::FN_NIL,     64'd0,                  8'h00);
        push_req(mpe_pkg::FN_PAYLOAD, 64'd0,                  8'h5a);

        // random phases across several capacity settings
        run_phase(32'hffff_ffff,                25, 20, 20);
        run_phase(32'($urandom_range(1, 40)),   25, 30, 30);
        run_phase(32'd0,                        15, 20, 25);
        // a stretch with no idling at all
        run_phase(32'($urandom_range(41, 2000)), 20, 0, 0);
        run_phase(32'($urandom),                20, 25, 15);
        run_phase(32'd1,                        10, 15, 30);
        // last part: no idling on either side
        run_phase(32'hffff_ffff,                20, 0, 0);

        settle();
        if (mismatches == 0 && enc_expected.size() == 0) begin
            $display("msgpack_value_encoder regression: pass");
        end else begin
            $display("msgpack_value_encoder regression: fail");
        end
        $finish;
    end

endmodule
